// ===== hdl/measure_grid_line_generator_macros.svh =====
// Assertion macros for the measure grid line generator.
// Expects clk and rst_n in scope where used.
`ifndef MEASURE_GRID_LINE_GENERATOR_MACROS_SVH
`define MEASURE_GRID_LINE_GENERATOR_MACROS_SVH

// same-cycle implication
`define MGLG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MGLG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mglg_pkg.sv =====
// Shared types and constants for the measure grid line generator.
// No dependencies.
package mglg_pkg;

    localparam int TICKS_PER_QUARTER  = 480;
    localparam int QUARTERS_PER_WHOLE = 4;
    localparam int TICKS_PER_WHOLE    = TICKS_PER_QUARTER * QUARTERS_PER_WHOLE;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int TICK_BITS_DEF   = 31;

    localparam int OP_W       = 2;
    localparam int INDEX_W    = 6;
    localparam int SIG_W      = 8;
    localparam int BAR_W      = 20;
    localparam int LINE_BAR_W = 21;
    localparam int BEAT_W     = 11;
    localparam int STEP_W     = 11;
    localparam int END_W      = 31;
    localparam int COUNT_W    = 7;
    localparam int BAR_LEN_W  = BEAT_W + SIG_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [SIG_W-1:0] DEFAULT_NUM = SIG_W'(4);
    localparam logic [SIG_W-1:0] DEFAULT_DEN = SIG_W'(4);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_RESTART = 2'd1,
        OP_NEXT    = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ASSIST_STEP = 2'd0,
        CFG_END_TICK    = 2'd1,
        CFG_ENTRY_COUNT = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_LOAD_DIV,
        ST_CHECK,
        ST_WALK,
        ST_MOD_BAR,
        ST_MOD_BEAT,
        ST_ADVANCE,
        ST_PUT
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic has_more;
        logic is_assist;
        logic is_bar;
    } line_flags_t;

endpackage

// ===== hdl/measure_grid_line_generator.sv =====
// Measure grid line generator: usage notes below.
// Top level; depends on mglg_pkg, mglg_seg_mem, mglg_divider, mglg_walker.
//
// Requests arrive on s_*: s_tuser holds the op (write entry, restart, next).
// A write entry stores one segment in the table; a restart rewinds the walk;
// neither produces a result. A next request produces
// one grid line on m_*. Segment arithmetic runs on one shared bit-serial
// divider of TICK_BITS+1 steps; a next request runs at most one division for
// a bar line and at most two for other lines, plus one more when a new
// segment is loaded.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; the next request is accepted and
// processed while it waits, and the sequencer holds its new line until
// m_tready frees the register. Configuration writes on cfg_* take effect at
// once and must be made while the block is idle; the block does not enforce this.
// Reset clears the walk and the configuration registers; the segment table
// holds no reset value, so only written entries may be walked.
module measure_grid_line_generator #(
    parameter int MAX_ENTRIES = mglg_pkg::MAX_ENTRIES_DEF,
    parameter int TICK_BITS   = mglg_pkg::TICK_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // entry_index, entry_start, entry_numerator, entry_denominator, entry_bar
    input  logic [((mglg_pkg::INDEX_W + TICK_BITS + 2 * mglg_pkg::SIG_W
                    + mglg_pkg::BAR_W + 7) / 8) * 8 - 1:0] s_tdata,
    // op
    input  logic [mglg_pkg::OP_W-1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // line_tick, line_bar, line_numerator, line_denominator, has_more
    output logic [((TICK_BITS + mglg_pkg::LINE_BAR_W + 2 * mglg_pkg::SIG_W + 1 + 7)
                   / 8) * 8 - 1:0] m_tdata,
    // is_bar_line, is_assist_line
    output logic [1:0] m_tuser,
    input  logic cfg_wr_en,
    input  logic [mglg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mglg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SIG_W     = mglg_pkg::SIG_W;
    localparam int INDEX_W   = mglg_pkg::INDEX_W;
    localparam int BAR_W     = mglg_pkg::BAR_W;
    localparam int LBAR_W    = mglg_pkg::LINE_BAR_W;
    localparam int ADDR_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int WORD_W    = TICK_BITS + 2 * SIG_W + BAR_W;
    localparam int OUT_W     = TICK_BITS + LBAR_W + 2 * SIG_W + 1;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int START_LO  = INDEX_W;
    localparam int NUM_LO    = START_LO + TICK_BITS;
    localparam int DEN_LO    = NUM_LO + SIG_W;
    localparam int BAR_LO    = DEN_LO + SIG_W;

    logic [mglg_pkg::STEP_W-1:0]  assist_reg;
    logic [mglg_pkg::END_W-1:0]   end_reg;
    logic [mglg_pkg::COUNT_W-1:0] count_reg;

    logic                 accept;
    logic [INDEX_W-1:0]   in_index;
    logic [TICK_BITS-1:0] in_start;
    logic [SIG_W-1:0]     in_num;
    logic [SIG_W-1:0]     in_den;
    logic [BAR_W-1:0]     in_bar;
    logic                 mem_wr_en;
    logic [ADDR_W-1:0]    mem_rd_addr;
    logic [WORD_W-1:0]    mem_rd_data;

    logic                          div_start;
    logic [TICK_BITS:0]            div_dividend;
    logic [mglg_pkg::BAR_LEN_W-1:0] div_divisor;
    logic [TICK_BITS:0]            div_quotient;
    logic [mglg_pkg::BAR_LEN_W-1:0] div_remainder;
    mglg_pkg::div_stat_t           div_stat;

    logic                  out_free;
    logic                  res_valid;
    logic [TICK_BITS-1:0]  res_tick;
    logic [LBAR_W-1:0]     res_bar;
    logic [SIG_W-1:0]      res_num;
    logic [SIG_W-1:0]      res_den;
    mglg_pkg::line_flags_t res_flags;

    logic                  m_tvalid_reg;
    logic [TICK_BITS-1:0]  out_tick_reg;
    logic [LBAR_W-1:0]     out_bar_reg;
    logic [SIG_W-1:0]      out_num_reg;
    logic [SIG_W-1:0]      out_den_reg;
    mglg_pkg::line_flags_t out_flags_reg;

    assign accept   = s_tvalid && s_tready;
    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_start = s_tdata[START_LO +: TICK_BITS];
    assign in_num   = s_tdata[NUM_LO +: SIG_W];
    assign in_den   = s_tdata[DEN_LO +: SIG_W];
    assign in_bar   = s_tdata[BAR_LO +: BAR_W];

    assign mem_wr_en = accept && mglg_pkg::op_t'(s_tuser) == mglg_pkg::OP_WRITE
                       && (32'(in_index) < 32'(MAX_ENTRIES));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assist_reg <= '0;
            end_reg    <= '0;
            count_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (mglg_pkg::cfg_index_t'(cfg_index))
                mglg_pkg::CFG_ASSIST_STEP: assist_reg <= cfg_wdata[mglg_pkg::STEP_W-1:0];
                mglg_pkg::CFG_END_TICK:    end_reg    <= cfg_wdata[mglg_pkg::END_W-1:0];
                mglg_pkg::CFG_ENTRY_COUNT: count_reg  <= cfg_wdata[mglg_pkg::COUNT_W-1:0];
                default:                   count_reg  <= count_reg;
            endcase
        end
    end

    mglg_seg_mem #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (ADDR_W),
        .WORD_W (WORD_W)
    ) u_seg_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (ADDR_W'(in_index)),
        .wr_data ({in_bar, in_den, in_num, in_start}),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    mglg_divider #(
        .DVD_W (TICK_BITS + 1)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .stat      (div_stat)
    );

    mglg_walker #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TICK_BITS   (TICK_BITS),
        .ADDR_W      (ADDR_W)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (accept),
        .req_op        (s_tuser),
        .ready         (s_tready),
        .assist_step   (assist_reg),
        .end_tick      (end_reg),
        .entry_count   (count_reg),
        .mem_rd_addr   (mem_rd_addr),
        .mem_start     (mem_rd_data[TICK_BITS-1:0]),
        .mem_num       (mem_rd_data[TICK_BITS +: SIG_W]),
        .mem_den       (mem_rd_data[TICK_BITS + SIG_W +: SIG_W]),
        .mem_bar       (mem_rd_data[TICK_BITS + 2 * SIG_W +: BAR_W]),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder),
        .div_stat      (div_stat),
        .out_free      (out_free),
        .res_valid     (res_valid),
        .res_tick      (res_tick),
        .res_bar       (res_bar),
        .res_num       (res_num),
        .res_den       (res_den),
        .res_flags     (res_flags)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_tick_reg  <= res_tick;
            out_bar_reg   <= res_bar;
            out_num_reg   <= res_num;
            out_den_reg   <= res_den;
            out_flags_reg <= res_flags;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({out_flags_reg.has_more, out_den_reg, out_num_reg,
                                  out_bar_reg, out_tick_reg});
    assign m_tuser  = {out_flags_reg.is_assist, out_flags_reg.is_bar};

endmodule

// ===== hdl/mglg_divider.sv =====
// Shared restoring divider: one quotient bit per cycle.
// Depends on mglg_pkg and the assertion macro header.
`include "measure_grid_line_generator_macros.svh"

module mglg_divider #(
    parameter int DVD_W = mglg_pkg::TICK_BITS_DEF + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DVD_W-1:0]               dividend,
    input  logic [mglg_pkg::BAR_LEN_W-1:0] divisor,
    output logic [DVD_W-1:0]               quotient,
    output logic [mglg_pkg::BAR_LEN_W-1:0] remainder,
    output mglg_pkg::div_stat_t            stat
);

    localparam int DSR_W = mglg_pkg::BAR_LEN_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DSR_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   trial_sub;
    logic             fits;

    assign trial     = {rem_reg, quo_reg[DVD_W-1]};
    assign fits      = trial >= {1'b0, dsr_reg};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign quotient   = quo_reg;
    assign remainder  = rem_reg;
    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;

    `MGLG_ASSERT_IMPL(a_div_no_restart, start, !busy_reg, "divider started while busy")
    `MGLG_ASSERT_NEXT(a_div_done, busy_reg && cnt_reg == CNT_W'(1), done_reg && !busy_reg,
                      "divider missed its done pulse")
    `MGLG_ASSERT_IMPL(a_div_rem, busy_reg, rem_reg < dsr_reg, "partial remainder not reduced")

endmodule

// ===== hdl/mglg_seg_mem.sv =====
// Segment table memory: one write port, one registered read port.
// Depends on nothing outside this file.
module mglg_seg_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WORD_W = 67
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mglg_walker.sv =====
// Sequencer for the segment walk: loads segments, drives the shared divider,
// steps the position. Depends on mglg_pkg and the assertion macro header.
`include "measure_grid_line_generator_macros.svh"

module mglg_walker #(
    parameter int MAX_ENTRIES = mglg_pkg::MAX_ENTRIES_DEF,
    parameter int TICK_BITS   = mglg_pkg::TICK_BITS_DEF,
    parameter int ADDR_W      = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic [mglg_pkg::OP_W-1:0]       req_op,
    output logic                            ready,
    input  logic [mglg_pkg::STEP_W-1:0]     assist_step,
    input  logic [mglg_pkg::END_W-1:0]      end_tick,
    input  logic [mglg_pkg::COUNT_W-1:0]    entry_count,
    output logic [ADDR_W-1:0]               mem_rd_addr,
    input  logic [TICK_BITS-1:0]            mem_start,
    input  logic [mglg_pkg::SIG_W-1:0]      mem_num,
    input  logic [mglg_pkg::SIG_W-1:0]      mem_den,
    input  logic [mglg_pkg::BAR_W-1:0]      mem_bar,
    output logic                            div_start,
    output logic [TICK_BITS:0]              div_dividend,
    output logic [mglg_pkg::BAR_LEN_W-1:0]  div_divisor,
    input  logic [TICK_BITS:0]              div_quotient,
    input  logic [mglg_pkg::BAR_LEN_W-1:0]  div_remainder,
    input  mglg_pkg::div_stat_t             div_stat,
    input  logic                            out_free,
    output logic                            res_valid,
    output logic [TICK_BITS-1:0]            res_tick,
    output logic [mglg_pkg::LINE_BAR_W-1:0] res_bar,
    output logic [mglg_pkg::SIG_W-1:0]      res_num,
    output logic [mglg_pkg::SIG_W-1:0]      res_den,
    output mglg_pkg::line_flags_t           res_flags
);

    localparam int POS_W  = TICK_BITS + 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > mglg_pkg::COUNT_W) ? CNT_W : mglg_pkg::COUNT_W;
    localparam int WIDE_W = (POS_W > mglg_pkg::END_W) ? POS_W : mglg_pkg::END_W;
    localparam int BEAT_W = mglg_pkg::BEAT_W;
    localparam int SIG_W  = mglg_pkg::SIG_W;
    localparam int LBAR_W = mglg_pkg::LINE_BAR_W;
    localparam int BLEN_W = mglg_pkg::BAR_LEN_W;

    mglg_pkg::seq_state_t state_reg, state_next;

    logic [CNT_W-1:0]  next_entry_reg;
    logic              limit_valid_reg;
    logic [WIDE_W-1:0] limit_reg;
    logic [POS_W-1:0]  position_reg;
    logic [TICK_BITS-1:0] origin_reg;
    logic [SIG_W-1:0]  active_num_reg;
    logic [SIG_W-1:0]  active_den_reg;
    logic [BEAT_W-1:0] beat_reg;
    logic [BEAT_W-1:0] advance_reg;
    logic [LBAR_W-1:0] bar_counter_reg;

    logic [TICK_BITS-1:0] res_tick_reg;
    logic [LBAR_W-1:0] res_bar_reg;
    logic [SIG_W-1:0]  res_num_reg;
    logic [SIG_W-1:0]  res_den_reg;
    logic              res_is_bar_reg;
    logic              res_assist_reg;

    logic [CNT_W-1:0]  count;
    logic              more_entries;
    logic              before_limit;
    logic [BLEN_W-1:0] bar_len;
    logic [POS_W-1:0]  diff;
    logic [SIG_W-1:0]  den_eff;
    logic [POS_W:0]    pos_sum;
    logic [BEAT_W-1:0] new_beat;
    logic              rem_zero;

    assign count = (CMP_W'(entry_count) > CMP_W'(MAX_ENTRIES))
                   ? CNT_W'(MAX_ENTRIES) : CNT_W'(entry_count);
    assign more_entries = CMP_W'(next_entry_reg) < CMP_W'(count);
    assign before_limit = limit_valid_reg && (WIDE_W'(position_reg) < limit_reg);
    assign bar_len      = BLEN_W'(beat_reg) * BLEN_W'(active_num_reg);
    assign diff         = position_reg - POS_W'(origin_reg);
    assign den_eff      = (mem_den == '0) ? mglg_pkg::DEFAULT_DEN : mem_den;
    assign pos_sum      = {1'b0, position_reg} + (POS_W + 1)'(advance_reg);
    assign new_beat     = div_quotient[BEAT_W-1:0];
    assign rem_zero     = div_remainder == '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mglg_pkg::ST_IDLE:
                if (req_valid && mglg_pkg::op_t'(req_op) == mglg_pkg::OP_NEXT)
                    state_next = mglg_pkg::ST_DECIDE;
            mglg_pkg::ST_DECIDE:
                if (before_limit)
                    state_next = mglg_pkg::ST_WALK;
                else if (more_entries)
                    state_next = mglg_pkg::ST_LOAD_A;
                else
                    state_next = mglg_pkg::ST_WALK;
            mglg_pkg::ST_LOAD_A:
                state_next = mglg_pkg::ST_LOAD_B;
            mglg_pkg::ST_LOAD_B:
                state_next = mglg_pkg::ST_LOAD_DIV;
            mglg_pkg::ST_LOAD_DIV:
                if (div_stat.done)
                    state_next = mglg_pkg::ST_CHECK;
            mglg_pkg::ST_CHECK:
                state_next = before_limit ? mglg_pkg::ST_WALK : mglg_pkg::ST_PUT;
            mglg_pkg::ST_WALK:
                state_next = (bar_len == '0) ? mglg_pkg::ST_PUT : mglg_pkg::ST_MOD_BAR;
            mglg_pkg::ST_MOD_BAR:
                if (div_stat.done)
                    state_next = rem_zero ? mglg_pkg::ST_ADVANCE : mglg_pkg::ST_MOD_BEAT;
            mglg_pkg::ST_MOD_BEAT:
                if (div_stat.done)
                    state_next = mglg_pkg::ST_ADVANCE;
            mglg_pkg::ST_ADVANCE:
                state_next = mglg_pkg::ST_PUT;
            mglg_pkg::ST_PUT:
                if (out_free)
                    state_next = mglg_pkg::ST_IDLE;
            default:
                state_next = mglg_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ready        = 1'b0;
        res_valid    = 1'b0;
        mem_rd_addr  = ADDR_W'(next_entry_reg);
        div_start    = 1'b0;
        div_dividend = diff;
        div_divisor  = bar_len;
        case (state_reg)
            mglg_pkg::ST_IDLE:
                ready = 1'b1;
            mglg_pkg::ST_LOAD_A:
            begin
                mem_rd_addr  = ADDR_W'(next_entry_reg) + ADDR_W'(1);
                div_start    = 1'b1;
                div_dividend = POS_W'(mglg_pkg::TICKS_PER_WHOLE);
                div_divisor  = BLEN_W'(den_eff);
            end
            mglg_pkg::ST_WALK:
                div_start = bar_len != '0;
            mglg_pkg::ST_MOD_BAR:
            begin
                div_start    = div_stat.done && !rem_zero;
                div_dividend = POS_W'(div_remainder);
                div_divisor  = BLEN_W'(beat_reg);
            end
            mglg_pkg::ST_PUT:
                res_valid = out_free;
            default:
                ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mglg_pkg::ST_IDLE;
            next_entry_reg  <= '0;
            limit_valid_reg <= 1'b0;
            limit_reg       <= '0;
            position_reg    <= '0;
            origin_reg      <= '0;
            active_num_reg  <= '0;
            active_den_reg  <= '0;
            beat_reg        <= '0;
            advance_reg     <= '0;
            bar_counter_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                mglg_pkg::ST_IDLE:
                    if (req_valid && mglg_pkg::op_t'(req_op) == mglg_pkg::OP_RESTART)
                    begin
                        next_entry_reg  <= '0;
                        limit_valid_reg <= 1'b0;
                        limit_reg       <= '0;
                        position_reg    <= '0;
                        origin_reg      <= '0;
                        active_num_reg  <= '0;
                        active_den_reg  <= '0;
                        beat_reg        <= '0;
                        advance_reg     <= '0;
                        bar_counter_reg <= '0;
                    end
                mglg_pkg::ST_LOAD_A:
                begin
                    active_num_reg  <= mem_num;
                    active_den_reg  <= mem_den;
                    origin_reg      <= mem_start;
                    position_reg    <= POS_W'(mem_start);
                    bar_counter_reg <= LBAR_W'(mem_bar) - LBAR_W'(1);
                end
                mglg_pkg::ST_LOAD_B:
                begin
                    limit_valid_reg <= 1'b1;
                    limit_reg <= (CMP_W'(next_entry_reg) + CMP_W'(1) < CMP_W'(count))
                                 ? WIDE_W'(mem_start) : WIDE_W'(end_tick);
                    next_entry_reg <= next_entry_reg + CNT_W'(1);
                end
                mglg_pkg::ST_LOAD_DIV:
                    if (div_stat.done)
                    begin
                        beat_reg    <= new_beat;
                        advance_reg <= (assist_step != '0 && assist_step < new_beat)
                                       ? assist_step : new_beat;
                    end
                mglg_pkg::ST_MOD_BAR:
                    if (div_stat.done && rem_zero)
                        bar_counter_reg <= bar_counter_reg + LBAR_W'(1);
                mglg_pkg::ST_ADVANCE:
                    position_reg <= pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
                default:
                    state_reg <= state_next;
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mglg_pkg::ST_CHECK:
                if (!before_limit)
                begin
                    res_tick_reg   <= '0;
                    res_bar_reg    <= '0;
                    res_num_reg    <= mglg_pkg::DEFAULT_NUM;
                    res_den_reg    <= mglg_pkg::DEFAULT_DEN;
                    res_is_bar_reg <= 1'b1;
                    res_assist_reg <= 1'b0;
                end
            mglg_pkg::ST_WALK:
                if (bar_len == '0)
                begin
                    res_tick_reg   <= '0;
                    res_bar_reg    <= '0;
                    res_num_reg    <= mglg_pkg::DEFAULT_NUM;
                    res_den_reg    <= mglg_pkg::DEFAULT_DEN;
                    res_is_bar_reg <= 1'b1;
                    res_assist_reg <= 1'b0;
                end
                else
                begin
                    res_tick_reg <= position_reg[TICK_BITS-1:0];
                    res_num_reg  <= active_num_reg;
                    res_den_reg  <= active_den_reg;
                end
            mglg_pkg::ST_MOD_BAR:
                if (div_stat.done)
                begin
                    res_is_bar_reg <= rem_zero;
                    res_assist_reg <= 1'b0;
                    res_bar_reg    <= rem_zero ? bar_counter_reg + LBAR_W'(1) : bar_counter_reg;
                end
            mglg_pkg::ST_MOD_BEAT:
                if (div_stat.done)
                    res_assist_reg <= !rem_zero;
            default:
                res_tick_reg <= res_tick_reg;
        endcase
    end

    assign res_tick           = res_tick_reg;
    assign res_bar            = res_bar_reg;
    assign res_num            = res_num_reg;
    assign res_den            = res_den_reg;
    assign res_flags.is_bar   = res_is_bar_reg;
    assign res_flags.is_assist = res_assist_reg;
    assign res_flags.has_more = WIDE_W'(position_reg) <= WIDE_W'(end_tick);

    `MGLG_ASSERT_IMPL(a_pos_in_segment, limit_valid_reg,
                      position_reg >= POS_W'(origin_reg), "position behind segment origin")
    `MGLG_ASSERT_IMPL(a_div_done_state, div_stat.done,
                      state_reg == mglg_pkg::ST_LOAD_DIV || state_reg == mglg_pkg::ST_MOD_BAR ||
                      state_reg == mglg_pkg::ST_MOD_BEAT, "divider result arrived unexpectedly")
    `MGLG_ASSERT_IMPL(a_entry_bound, 1'b1,
                      CMP_W'(next_entry_reg) <= CMP_W'(MAX_ENTRIES), "walk ran past table")

endmodule
